// ===== src/jli_pkg.sv =====
// Shared types, widths and codes for the joint linear interpolator.
// No dependencies; every other file of the block imports this package.
package jli_pkg;

   localparam int POS_W        = 16;                // Q4.12 joint position
   localparam int DIFF_W       = POS_W + 1;         // magnitude of target - start
   localparam int STEP_W       = 16;                // step counter and step total
   localparam int RATE_W       = 10;
   localparam int THR_W        = 12;
   localparam int SPEED_W      = 15;
   localparam int REQ_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;
   localparam int FIELD_JOINTS = 3;                 // joints with a port of their own

   // move: maxdelta * rate, divided by speed
   localparam int SPROD_W      = DIFF_W + RATE_W;
   localparam int SDIV_HI_W    = SPROD_W - STEP_W;
   localparam int SDIV_ITERS   = STEP_W;
   localparam int SDIV_CNT_W   = $clog2(SDIV_ITERS);

   // tick: |delta| * step, divided by total steps
   localparam int TPROD_W      = DIFF_W + STEP_W;
   localparam int TICK_ITERS   = DIFF_W;
   localparam int TICK_CNT_W   = $clog2(TICK_ITERS);

   typedef logic signed [POS_W-1:0] pos_type;

   localparam logic [REQ_W-1:0] REQ_FEEDBACK = 2'd0;
   localparam logic [REQ_W-1:0] REQ_MOVE     = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_STEP      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FINAL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_AT_TARGET = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_STARTED   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd1;

   typedef struct packed {
      logic fb_load;     // store measured position
      logic move_load;   // latch start, take target
      logic mul_start;   // form |delta| * step and load the divider
      logic div_step;    // one quotient bit
   } lane_ctrl_type;

endpackage

// ===== src/jli_lane.sv =====
// One joint lane: measured and start positions, |target - start| and the
// bit-serial interpolation divide. Depends on jli_pkg.
module jli_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  jli_pkg::lane_ctrl_type        ctrl,
   input  jli_pkg::pos_type              pos,
   input  logic [jli_pkg::STEP_W-1:0]    step,
   input  logic [jli_pkg::STEP_W-1:0]    total,
   output logic [jli_pkg::DIFF_W-1:0]    abs_delta,
   output jli_pkg::pos_type              origin,
   output jli_pkg::pos_type              cmd
);
   import jli_pkg::*;

   pos_type                    measured_ff, measured_in;
   pos_type                    start_ff, start_in;
   logic [DIFF_W-1:0]          absd_ff, absd_in;
   logic                       neg_ff, neg_in;
   logic [STEP_W-1:0]          rem_ff, rem_in;
   logic [DIFF_W-1:0]          quo_ff, quo_in;

   logic signed [DIFF_W-1:0]   diff;
   logic [TPROD_W-1:0]         prod;
   logic [STEP_W:0]            trial;
   logic [STEP_W:0]            trial_sub;
   logic                       ge;
   logic signed [DIFF_W:0]     start_x;
   logic signed [DIFF_W:0]     quo_x;
   logic signed [DIFF_W:0]     sum;

   always_comb begin
      diff = DIFF_W'($signed(pos)) - DIFF_W'($signed(measured_ff));
      prod = TPROD_W'(absd_ff) * TPROD_W'(step);
      trial     = {rem_ff, quo_ff[DIFF_W-1]};
      trial_sub = trial - {1'b0, total};
      ge        = trial >= {1'b0, total};

      measured_in = measured_ff;
      start_in    = start_ff;
      absd_in     = absd_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;

      if (ctrl.fb_load) begin
         measured_in = pos;
      end
      if (ctrl.move_load) begin
         start_in = measured_ff;
         neg_in   = diff[DIFF_W-1];
         absd_in  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      end
      // high part is below total since step never exceeds it
      if (ctrl.mul_start) begin
         rem_in = prod[TPROD_W-1 -: STEP_W];
         quo_in = prod[DIFF_W-1:0];
      end else if (ctrl.div_step) begin
         rem_in = ge ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
         quo_in = {quo_ff[DIFF_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measured_ff <= '0;
         start_ff    <= '0;
      end else begin
         measured_ff <= measured_in;
         start_ff    <= start_in;
      end
      absd_ff <= absd_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // quotient truncated toward zero: apply the sign after dividing magnitudes
   always_comb begin
      start_x = (DIFF_W+1)'(start_ff);
      quo_x   = $signed({1'b0, quo_ff});
      sum     = neg_ff ? (start_x - quo_x) : (start_x + quo_x);
   end

   assign abs_delta = absd_ff;
   assign origin    = start_ff;
   assign cmd       = sum[POS_W-1:0];

endmodule

// ===== src/jli_step_div.sv =====
// Step-total divider: (maxdelta * rate) / speed, one quotient bit a cycle,
// saturated at the top of the step range and raised to one. Depends on jli_pkg.
module jli_step_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [jli_pkg::SPROD_W-1:0]   dividend,
   input  logic [jli_pkg::SPEED_W-1:0]   divisor,
   output logic                          done,
   output logic [jli_pkg::STEP_W-1:0]    steps
);
   import jli_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [SDIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    sat_ff, sat_in;
   logic [SPEED_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]       quo_ff, quo_in;

   logic [SPEED_W:0]        trial;
   logic [SPEED_W:0]        trial_sub;
   logic                    ge;

   always_comb begin
      trial     = {rem_ff, quo_ff[STEP_W-1]};
      trial_sub = trial - {1'b0, divisor};
      ge        = trial >= {1'b0, divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sat_in  = sat_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // high part not below the divisor: quotient needs more than STEP_W bits
         sat_in  = SPEED_W'(dividend[SPROD_W-1 -: SDIV_HI_W]) >= divisor;
         rem_in  = SPEED_W'(dividend[SPROD_W-1 -: SDIV_HI_W]);
         quo_in  = dividend[STEP_W-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? trial_sub[SPEED_W-1:0] : trial[SPEED_W-1:0];
         quo_in = {quo_ff[STEP_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SDIV_CNT_W'(SDIV_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sat_ff <= sat_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done  = done_ff;
   assign steps = sat_ff ? '1 : ((quo_ff == '0) ? STEP_W'(1) : quo_ff);

endmodule

// ===== src/joint_linear_interpolator_unit.sv =====
// Top level of the joint-space linear interpolator: request decode, lane
// array, max merge, step divider and result register. Depends on jli_pkg,
// jli_lane and jli_step_div.
//
//   channel | direction | transfer moves
//   --------+-----------+--------------------------------------------------
//   req_    | in        | type, three joint positions, speed
//   rsp_    | out       | three commanded joint positions, status
//   csr_    | in        | register index and write data (always ready)
//
// Feedback, reserved types and ticks while no move runs give no response. A tick
// in a move runs one multiply and 17 quotient bits in every lane. A move runs the
// max merge, the threshold compare and the 16-bit serial step divider; one
// already at target skips the divider. Reset is synchronous and brings back the
// register defaults and an idle, zeroed trajectory. A stalled rsp_ holds the
// block in its emit cycle; req_ready stays low until the result register is free.
module joint_linear_interpolator_unit #(
   parameter int NUM_JOINTS = 3
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [jli_pkg::REQ_W-1:0]         req_type,
   input  jli_pkg::pos_type                  req_pos_joint0,
   input  jli_pkg::pos_type                  req_pos_joint1,
   input  jli_pkg::pos_type                  req_pos_joint2,
   input  logic [jli_pkg::SPEED_W-1:0]       req_speed,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output jli_pkg::pos_type                  rsp_cmd_joint0,
   output jli_pkg::pos_type                  rsp_cmd_joint1,
   output jli_pkg::pos_type                  rsp_cmd_joint2,
   output logic [jli_pkg::STATUS_W-1:0]      rsp_status,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [jli_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jli_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import jli_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MAX      = 3'd1;
   localparam logic [2:0] ST_CMP      = 3'd2;
   localparam logic [2:0] ST_SDIV     = 3'd3;
   localparam logic [2:0] ST_TICK_MUL = 3'd4;
   localparam logic [2:0] ST_TICK_DIV = 3'd5;
   localparam logic [2:0] ST_EMIT     = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [THR_W-1:0]        thr_ff, thr_in;
   logic [SPEED_W-1:0]      speed_ff, speed_in;
   logic [DIFF_W-1:0]       maxd_ff, maxd_in;
   logic [STEP_W-1:0]       step_count_ff, step_count_in;
   logic [STEP_W-1:0]       total_steps_ff, total_steps_in;
   logic                    moving_ff, moving_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [TICK_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pos_type                 rsp_cmd_ff [FIELD_JOINTS];
   pos_type                 rsp_cmd_in [FIELD_JOINTS];
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic                    req_fire;
   logic [STEP_W-1:0]       step_next;
   logic [DIFF_W-1:0]       maxd_tree;
   lane_ctrl_type           lane_ctrl;
   logic                    sdiv_start;
   logic                    sdiv_done;
   logic [STEP_W-1:0]       sdiv_steps;
   logic [SPROD_W-1:0]      sdiv_dividend;

   logic [DIFF_W-1:0]       lane_absd  [NUM_JOINTS];
   pos_type                 lane_start [NUM_JOINTS];
   pos_type                 lane_cmd   [NUM_JOINTS];
   pos_type                 emit_val   [FIELD_JOINTS];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      lane_ctrl.fb_load   = req_fire && (req_type == REQ_FEEDBACK);
      lane_ctrl.move_load = req_fire && (req_type == REQ_MOVE);
      lane_ctrl.mul_start = (state_ff == ST_TICK_MUL);
      lane_ctrl.div_step  = (state_ff == ST_TICK_DIV);
   end

   // ---------------------------------------------------------------- lanes
   for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
      pos_type fpos;
      if (j == 0) begin : g_f0
         assign fpos = req_pos_joint0;
      end else if (j == 1) begin : g_f1
         assign fpos = req_pos_joint1;
      end else if (j == 2) begin : g_f2
         assign fpos = req_pos_joint2;
      end else begin : g_fz
         // joints without a port of their own sit at zero
         assign fpos = '0;
      end

      jli_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .pos       (fpos),
         .step      (step_count_ff),
         .total     (total_steps_ff),
         .abs_delta (lane_absd[j]),
         .origin    (lane_start[j]),
         .cmd       (lane_cmd[j])
      );
   end

   // merge: largest joint distance
   always_comb begin
      maxd_tree = '0;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         if (lane_absd[j] > maxd_tree) begin
            maxd_tree = lane_absd[j];
         end
      end
   end

   for (genvar j = 0; j < FIELD_JOINTS; j++) begin : g_emit
      if (j < NUM_JOINTS) begin : g_live
         assign emit_val[j] = ((res_status_ff == STATUS_STEP) ||
                               (res_status_ff == STATUS_FINAL)) ?
                              lane_cmd[j] : lane_start[j];
      end else begin : g_dead
         assign emit_val[j] = '0;
      end
   end

   // ---------------------------------------------------------- step divider
   assign sdiv_dividend = SPROD_W'(maxd_ff) * SPROD_W'(rate_ff);

   jli_step_div u_step_div (
      .clock    (clock),
      .reset    (reset),
      .start    (sdiv_start),
      .dividend (sdiv_dividend),
      .divisor  (speed_ff),
      .done     (sdiv_done),
      .steps    (sdiv_steps)
   );

   // --------------------------------------------------------------- control
   always_comb begin
      state_in       = state_ff;
      rate_in        = rate_ff;
      thr_in         = thr_ff;
      speed_in       = speed_ff;
      maxd_in        = maxd_ff;
      step_count_in  = step_count_ff;
      total_steps_in = total_steps_ff;
      moving_in      = moving_ff;
      res_status_in  = res_status_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_cmd_in     = rsp_cmd_ff;
      rsp_status_in  = rsp_status_ff;
      sdiv_start     = 1'b0;
      step_next      = step_count_ff + 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICK_RATE: rate_in = csr_wdata[RATE_W-1:0];
            CSR_THRESHOLD: thr_in  = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_type)
                  REQ_MOVE: begin
                     speed_in = (req_speed == '0) ? SPEED_W'(1) : req_speed;
                     state_in = ST_MAX;
                  end
                  REQ_TICK: begin
                     // step stays below total while moving, so no clamp
                     if (moving_ff) begin
                        step_count_in = step_next;
                        if (step_next >= total_steps_ff) begin
                           moving_in     = 1'b0;
                           res_status_in = STATUS_FINAL;
                        end else begin
                           res_status_in = STATUS_STEP;
                        end
                        state_in = ST_TICK_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MAX: begin
            maxd_in  = maxd_tree;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (maxd_ff < DIFF_W'(thr_ff)) begin
               moving_in     = 1'b0;
               res_status_in = STATUS_AT_TARGET;
               state_in      = ST_EMIT;
            end else begin
               sdiv_start = 1'b1;
               state_in   = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (sdiv_done) begin
               total_steps_in = sdiv_steps;
               step_count_in  = '0;
               moving_in      = 1'b1;
               res_status_in  = STATUS_STARTED;
               state_in       = ST_EMIT;
            end
         end
         ST_TICK_MUL: begin
            div_cnt_in = '0;
            state_in   = ST_TICK_DIV;
         end
         ST_TICK_DIV: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == TICK_CNT_W'(TICK_ITERS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cmd_in    = emit_val;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rate_ff        <= RATE_W'(100);
         thr_ff         <= THR_W'(4);
         step_count_ff  <= '0;
         total_steps_ff <= STEP_W'(1);
         moving_ff      <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         res_status_ff  <= STATUS_STEP;
      end else begin
         state_ff       <= state_in;
         rate_ff        <= rate_in;
         thr_ff         <= thr_in;
         step_count_ff  <= step_count_in;
         total_steps_ff <= total_steps_in;
         moving_ff      <= moving_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         res_status_ff  <= res_status_in;
      end
      speed_ff      <= speed_in;
      maxd_ff       <= maxd_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cmd_joint0 = rsp_cmd_ff[0];
   assign rsp_cmd_joint1 = rsp_cmd_ff[1];
   assign rsp_cmd_joint2 = rsp_cmd_ff[2];
   assign rsp_status     = rsp_status_ff;

   // ------------------------------------------------------------ assertions
   a_step_below_total: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (step_count_ff < total_steps_ff))
      else $error("step count reached total while still moving");

   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      total_steps_ff != '0)
      else $error("step total is zero");

   a_move_start_status: assert property (@(posedge clock) disable iff (reset)
      $rose(moving_ff) |-> (state_ff == ST_EMIT) && (res_status_ff == STATUS_STARTED))
      else $error("move began without a move-started result");

   a_sdiv_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sdiv_done |-> (state_ff == ST_SDIV))
      else $error("step divider finished outside its wait state");

   a_final_clears_moving: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_MUL) && (res_status_ff == STATUS_FINAL) |-> !moving_ff)
      else $error("final step left the move running");

endmodule
